/* design/jtl_pkg.sv */
// Shared types and constants for the JSON token lexer.
`default_nettype none
package jtl_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } text_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic        last_of_run;
  } token_t;

  // Everything one text word produces: one token, or two when two is set.
  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } bundle_t;

  localparam logic [3:0] KIND_LCURLY  = 4'd0;
  localparam logic [3:0] KIND_RCURLY  = 4'd1;
  localparam logic [3:0] KIND_LSQUARE = 4'd2;
  localparam logic [3:0] KIND_RSQUARE = 4'd3;
  localparam logic [3:0] KIND_COLON   = 4'd4;
  localparam logic [3:0] KIND_COMMA   = 4'd5;
  localparam logic [3:0] KIND_SPACE   = 4'd6;
  localparam logic [3:0] KIND_BOOL    = 4'd7;
  localparam logic [3:0] KIND_NULL    = 4'd8;
  localparam logic [3:0] KIND_NUMBER  = 4'd9;
  localparam logic [3:0] KIND_STRING  = 4'd10;
  localparam logic [3:0] KIND_ERROR   = 4'd11;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage
`default_nettype wire

/* design/json_token_lexer.sv */
// Top level of the streaming JSON token lexer.
`default_nettype none
// Takes JSON text one byte word per cycle and delivers tokens (kind, start offset,
// length, last-of-run flag) one per cycle on the token channel while token_ready
// is high. A byte word is taken whenever the four-entry bundle queue has room, so
// bytes flow at one per cycle until it fills; each byte yields zero, one or two
// tokens, and the single output register delivers one token per cycle, so a byte
// that both closes a token and opens a one-byte token yields two tokens. A token
// goes through the bundle queue and output register after its closing byte. A text
// word flagged text_end closes any open token and returns the lexer to offset zero.
module json_token_lexer #(
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            text_valid,
  output logic                 text_ready,
  input  wire jtl_pkg::text_t  text,
  output logic                 token_valid,
  input  wire logic            token_ready,
  output jtl_pkg::token_t      token
);

  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  jtl_pkg::bundle_t push_data;
  jtl_pkg::bundle_t head;

  jtl_lexer #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_lexer (
    .clk       (clk),
    .rst       (rst),
    .text_valid(text_valid),
    .text_ready(text_ready),
    .text      (text),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  jtl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  jtl_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .token_valid(token_valid),
    .token_ready(token_ready),
    .token      (token)
  );

endmodule
`default_nettype wire

/* design/jtl_lexer.sv */
// Front end: takes text words, tracks the open token and builds token bundles.
`default_nettype none
module jtl_lexer #(
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            text_valid,
  output logic                 text_ready,
  input  wire jtl_pkg::text_t  text,
  output logic                 push,
  output jtl_pkg::bundle_t     push_data,
  input  wire logic            full
);

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_SPACE  = 3'd1;
  localparam logic [2:0] M_STRING = 3'd2;
  localparam logic [2:0] M_ESCAPE = 3'd3;
  localparam logic [2:0] M_HEX    = 3'd4;
  localparam logic [2:0] M_NUMBER = 3'd5;
  localparam logic [2:0] M_WORD   = 3'd6;

  localparam logic [31:0] KW_NULL  = "null";
  localparam logic [31:0] KW_TRUE  = "true";
  localparam logic [39:0] KW_FALSE = "false";

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  logic [2:0]                mode, mode_next;
  logic [2:0]                hex_left, hex_left_next;
  logic [POSITION_WIDTH-1:0] begin_pos, begin_pos_next;
  logic [POSITION_WIDTH-1:0] pos, pos_next;
  logic [2:0]                kw_flags, kw_flags_next;
  logic [2:0]                word_len, word_len_next;

  logic [7:0]                c;
  logic                      accept;
  logic                      restart;
  logic                      close_valid;
  logic [3:0]                close_kind;
  logic                      close_through;
  logic                      start_valid;
  logic [3:0]                start_kind;
  logic [POSITION_WIDTH-1:0] len_before;
  logic [POSITION_WIDTH-1:0] len_through;
  logic [2:0]                hex_dec;
  logic [3:0]                word_kind;
  jtl_pkg::token_t           close_tok, start_tok;

  function automatic logic is_ws(logic [7:0] b);
    return b == 8'h20 || b == 8'h0D || b == 8'h0A || b == 8'h09;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_hex(logic [7:0] b);
    return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic is_struct(logic [7:0] b);
    return b == "{" || b == "}" || b == "[" || b == "]" || b == ":" || b == ",";
  endfunction

  // Which keywords still agree with letter b at place i: {false, true, null}.
  function automatic logic [2:0] kw_hit(logic [2:0] i, logic [7:0] b);
    logic [2:0] hit;
    hit = 3'b000;
    unique case (i)
      3'd0: hit = {b == KW_FALSE[39:32], b == KW_TRUE[31:24], b == KW_NULL[31:24]};
      3'd1: hit = {b == KW_FALSE[31:24], b == KW_TRUE[23:16], b == KW_NULL[23:16]};
      3'd2: hit = {b == KW_FALSE[23:16], b == KW_TRUE[15:8],  b == KW_NULL[15:8]};
      3'd3: hit = {b == KW_FALSE[15:8],  b == KW_TRUE[7:0],   b == KW_NULL[7:0]};
      3'd4: hit = {b == KW_FALSE[7:0], 2'b00};
      default: hit = 3'b000;
    endcase
    return hit;
  endfunction

  assign c          = text.text_byte;
  assign text_ready = !full;
  assign accept     = text_valid && text_ready;

  assign len_before  = pos - begin_pos;
  assign len_through = (len_before != POS_MAX) ? len_before + 1'b1 : len_before;
  assign hex_dec     = (hex_left != 3'd0) ? hex_left - 3'd1 : hex_left;

  always_comb begin
    priority if (kw_flags[0] && word_len == 3'd4) begin
      word_kind = jtl_pkg::KIND_NULL;
    end else if (kw_flags[1] && word_len == 3'd4) begin
      word_kind = jtl_pkg::KIND_BOOL;
    end else if (kw_flags[2] && word_len == 3'd5) begin
      word_kind = jtl_pkg::KIND_BOOL;
    end else begin
      word_kind = jtl_pkg::KIND_ERROR;
    end
  end

  always_comb begin
    mode_next      = mode;
    hex_left_next  = hex_left;
    begin_pos_next = begin_pos;
    kw_flags_next  = kw_flags;
    word_len_next  = word_len;
    pos_next       = (pos != POS_MAX) ? pos + 1'b1 : pos;
    close_valid    = 1'b0;
    close_kind     = jtl_pkg::KIND_ERROR;
    close_through  = 1'b0;
    restart        = 1'b0;
    start_valid    = 1'b0;
    start_kind     = jtl_pkg::KIND_ERROR;

    if (text.text_end) begin
      unique case (mode)
        M_SPACE: begin
          close_valid = 1'b1;
          close_kind  = jtl_pkg::KIND_SPACE;
        end
        M_NUMBER: begin
          close_valid = 1'b1;
          close_kind  = jtl_pkg::KIND_NUMBER;
        end
        M_WORD: begin
          close_valid = 1'b1;
          close_kind  = word_kind;
        end
        M_STRING, M_ESCAPE, M_HEX: begin
          close_valid = 1'b1;
        end
        default: ;
      endcase
      mode_next      = M_IDLE;
      hex_left_next  = 3'd0;
      begin_pos_next = '0;
      pos_next       = '0;
      kw_flags_next  = 3'b000;
      word_len_next  = 3'd0;
    end else begin
      unique case (mode)
        M_SPACE: begin
          if (!is_ws(c)) begin
            close_valid = 1'b1;
            close_kind  = jtl_pkg::KIND_SPACE;
            restart     = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_ws(c) || is_struct(c)) begin
            close_valid = 1'b1;
            close_kind  = jtl_pkg::KIND_NUMBER;
            restart     = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha(c)) begin
            kw_flags_next = kw_flags & kw_hit(word_len, c);
            word_len_next = (word_len != 3'd7) ? word_len + 3'd1 : word_len;
          end else begin
            close_valid = 1'b1;
            close_kind  = word_kind;
            restart     = 1'b1;
          end
        end
        M_STRING: begin
          if (c == CH_QUOTE) begin
            close_valid   = 1'b1;
            close_kind    = jtl_pkg::KIND_STRING;
            close_through = 1'b1;
            mode_next     = M_IDLE;
          end else if (c == CH_BSLASH) begin
            mode_next = M_ESCAPE;
          end
        end
        M_ESCAPE: begin
          if (c == CH_U) begin
            mode_next     = M_HEX;
            hex_left_next = 3'd4;
          end else if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == "b" ||
                       c == "f" || c == "n" || c == "r" || c == "t") begin
            mode_next = M_STRING;
          end else begin
            close_valid = 1'b1;
            restart     = 1'b1;
          end
        end
        M_HEX: begin
          if (is_hex(c)) begin
            hex_left_next = hex_dec;
            if (hex_dec == 3'd0) begin
              mode_next = M_STRING;
            end
          end else begin
            hex_left_next = 3'd0;
            close_valid   = 1'b1;
            restart       = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase
    end

    // The byte that ended the previous token, or any byte taken while idle, opens the next one.
    if (restart) begin
      begin_pos_next = pos;
      mode_next      = M_IDLE;
      priority if (is_ws(c)) begin
        mode_next = M_SPACE;
      end else if (c == CH_QUOTE) begin
        mode_next = M_STRING;
      end else if (c == "-" || c == "e" || c == "E" || is_digit(c)) begin
        mode_next = M_NUMBER;
      end else if (is_alpha(c)) begin
        mode_next     = M_WORD;
        kw_flags_next = kw_hit(3'd0, c);
        word_len_next = 3'd1;
      end else begin
        start_valid = 1'b1;
        priority if (c == "{") begin
          start_kind = jtl_pkg::KIND_LCURLY;
        end else if (c == "}") begin
          start_kind = jtl_pkg::KIND_RCURLY;
        end else if (c == "[") begin
          start_kind = jtl_pkg::KIND_LSQUARE;
        end else if (c == "]") begin
          start_kind = jtl_pkg::KIND_RSQUARE;
        end else if (c == ":") begin
          start_kind = jtl_pkg::KIND_COLON;
        end else if (c == ",") begin
          start_kind = jtl_pkg::KIND_COMMA;
        end else begin
          start_kind = jtl_pkg::KIND_ERROR;
        end
      end
    end
  end

  always_comb begin
    close_tok.token_kind   = close_kind;
    close_tok.token_start  = 32'(begin_pos);
    close_tok.token_length = close_through ? 32'(len_through) : 32'(len_before);
    close_tok.last_of_run  = !start_valid;

    start_tok.token_kind   = start_kind;
    start_tok.token_start  = 32'(pos);
    start_tok.token_length = 32'd1;
    start_tok.last_of_run  = 1'b1;

    push_data.two    = close_valid && start_valid;
    push_data.first  = close_valid ? close_tok : start_tok;
    push_data.second = start_tok;
    push             = accept && (close_valid || start_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      hex_left  <= 3'd0;
      begin_pos <= '0;
      pos       <= '0;
      kw_flags  <= 3'b000;
      word_len  <= 3'd0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_left  <= hex_left_next;
      begin_pos <= begin_pos_next;
      pos       <= pos_next;
      kw_flags  <= kw_flags_next;
      word_len  <= word_len_next;
    end
  end

endmodule
`default_nettype wire

/* design/jtl_queue.sv */
// Short queue of token bundles between the lexer and the output stage.
`default_nettype none
module jtl_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire jtl_pkg::bundle_t  push_data,
  output logic                   full,
  input  wire logic              pop,
  output jtl_pkg::bundle_t       head,
  output logic                   empty
);

  jtl_pkg::bundle_t                 entries [jtl_pkg::QUEUE_DEPTH];
  logic [jtl_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [jtl_pkg::QUEUE_PTR_W-1:0]  rd_ptr;
  logic [jtl_pkg::QUEUE_CNT_W-1:0]  count;

  assign full  = count == jtl_pkg::QUEUE_CNT_W'(jtl_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/jtl_emit.sv */
// Back end: splits bundles into single tokens and holds the output register.
`default_nettype none
module jtl_emit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire jtl_pkg::bundle_t  head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   token_valid,
  input  wire logic              token_ready,
  output jtl_pkg::token_t        token
);

  logic            load;
  logic            second_valid;
  jtl_pkg::token_t second;

  assign load = !token_valid || token_ready;
  assign pop  = load && !second_valid && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid  <= 1'b0;
      second_valid <= 1'b0;
    end else if (load) begin
      if (second_valid) begin
        token_valid  <= 1'b1;
        second_valid <= 1'b0;
      end else begin
        token_valid  <= !empty;
        second_valid <= !empty && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (second_valid) begin
        token <= second;
      end else if (!empty) begin
        token  <= head.first;
        second <= head.second;
      end
    end
  end

endmodule
`default_nettype wire

/* design/jtl_checker.sv */
// Port-level assertions for the JSON token lexer and their binding.
`default_nettype none
module jtl_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            text_valid,
  input wire logic            text_ready,
  input wire jtl_pkg::text_t  text,
  input wire logic            token_valid,
  input wire logic            token_ready,
  input wire jtl_pkg::token_t token
);

  // A stalled token word must hold.
  a_token_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=> token_valid && $stable(token))
    else $error("token word changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> token.token_kind <= jtl_pkg::KIND_ERROR)
    else $error("token kind out of range");

  // Braces, brackets, colon and comma are always single-byte tokens.
  a_struct_len: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.token_kind <= jtl_pkg::KIND_COMMA |-> token.token_length == 32'd1)
    else $error("structural token with length other than one");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !token_valid)
    else $error("token word shown straight after reset");

  // An end marker never opens a token, so it alone cannot produce a token next cycle
  // when nothing was pending and the output was empty.
  a_end_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && text_valid && text_ready && text.text_end |=> !token_valid)
    else $error("end marker straight after reset produced a token");

endmodule

bind json_token_lexer jtl_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .text_valid (text_valid),
  .text_ready (text_ready),
  .text       (text),
  .token_valid(token_valid),
  .token_ready(token_ready),
  .token      (token)
);
`default_nettype wire
